// File: design/assert_macros.svh
// assertion macros used by the encoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_CLK_ALWAYS(label, clk, prop)

`endif

`endif

// File: design/b32e_pkg.sv
// types, constants and character lookup for the base32 stream encoder
package b32e_pkg;

  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_2     = 7'h32;
  localparam logic [6:0] PAD_CHAR   = 7'h39;
  localparam int unsigned ALPHA_LETTERS = 26;
  localparam logic [3:0] SYMBOL_BITS = 4'd5;

  typedef logic [11:0] acc_t;
  typedef logic [3:0]  bit_cnt_t;
  typedef logic [2:0]  grp_pos_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       is_pad;
    logic       done;
    bit_cnt_t   bits_nxt;
  } b32e_char_t;

  function automatic logic [6:0] b32e_symbol(input logic [4:0] idx);
    logic [6:0] code;
    if (idx < 5'(ALPHA_LETTERS)) begin
      code = CHAR_A + 7'(idx);
    end else begin
      code = CHAR_2 + 7'(idx) - 7'(ALPHA_LETTERS);
    end
    return code;
  endfunction

endpackage

// File: design/b32e_char_gen.sv
// picks the next output character from the held bits and the group position
module b32e_char_gen import b32e_pkg::*; (
  input  acc_t       acc,
  input  bit_cnt_t   bits,
  input  grp_pos_t   gpos,
  input  logic       last,
  output b32e_char_t chr
);

  logic [11:0] shifted;
  logic [4:0]  idx;
  logic [4:0]  flush_idx;
  grp_pos_t    gpos_inc;

  assign shifted   = acc >> (bits - SYMBOL_BITS);
  assign flush_idx = {1'b0, acc[3:0]} << (3'd5 - bits[2:0]);
  assign gpos_inc  = gpos + 3'd1;

  always_comb begin
    idx           = shifted[4:0];
    chr.is_pad    = 1'b0;
    chr.bits_nxt  = '0;
    if (bits >= SYMBOL_BITS) begin
      chr.bits_nxt = bits - SYMBOL_BITS;
    end else if (bits != '0) begin
      idx = flush_idx;
    end else begin
      chr.is_pad = 1'b1;
    end
    chr.char_code = chr.is_pad ? PAD_CHAR : b32e_symbol(idx);
    if (last) begin
      chr.done = (chr.bits_nxt == '0) && (gpos_inc == '0);
    end else begin
      chr.done = chr.bits_nxt < SYMBOL_BITS;
    end
  end

endmodule

// File: design/base32_stream_encoder_core.sv
// Base32 stream encoder (A-Z, 2-7 alphabet, '9' pad). Bytes enter MSB first
// and leave as one character per clock while the output is not stalled: a plain
// byte yields one or two characters, a byte flagged final up to eight as the
// leftover bits are flushed and the 8-character group is padded. The next byte
// is accepted in the same cycle that the previous one's last character moves
// into the single character output register. No clearing pass after reset.
`include "assert_macros.svh"

module base32_stream_encoder_core import b32e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char_code,
  output logic       out_is_pad,
  output logic       out_final_char
);

  logic       busy_r, busy_nxt;
  acc_t       acc_r, acc_nxt;
  bit_cnt_t   bits_r, bits_nxt;
  grp_pos_t   gpos_r, gpos_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r;
  logic [6:0] out_char_code_r;
  logic       out_is_pad_r;
  logic       out_final_char_r;

  b32e_char_t chr;
  logic       step;
  logic       in_take;
  bit_cnt_t   left_cnt;

  b32e_char_gen u_char_gen (
    .acc  (acc_r),
    .bits (bits_r),
    .gpos (gpos_r),
    .last (last_r),
    .chr  (chr)
  );

  assign step     = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (step && chr.done);
  assign in_take  = in_valid && in_ready;
  assign left_cnt = busy_r ? chr.bits_nxt : bits_r;

  always_comb begin
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    bits_nxt = bits_r;
    gpos_nxt = gpos_r;
    last_nxt = last_r;
    if (step) begin
      bits_nxt = chr.bits_nxt;
      gpos_nxt = (chr.done && last_r) ? '0 : gpos_r + 3'd1;
      if (chr.done) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_take) begin
      busy_nxt = 1'b1;
      acc_nxt  = {acc_r[3:0], in_data_byte};
      bits_nxt = left_cnt + 4'd8;
      last_nxt = in_final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      bits_r      <= '0;
      gpos_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      bits_r <= bits_nxt;
      gpos_r <= gpos_nxt;
      last_r <= last_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (step) begin
      out_char_code_r  <= chr.char_code;
      out_is_pad_r     <= chr.is_pad;
      out_final_char_r <= chr.done && last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_code  = out_char_code_r;
  assign out_is_pad     = out_is_pad_r;
  assign out_final_char = out_final_char_r;

  // leftover between bytes never reaches a full symbol
  `ASSERT_CLK(a_idle_leftover, clk, rst_n, !busy_r |-> bits_r < SYMBOL_BITS)
  `ASSERT_CLK(a_take_busy, clk, rst_n, in_take |=> busy_r)
  // pads only come after all data bits of a final byte are gone
  `ASSERT_CLK(a_pad_final, clk, rst_n, (step && chr.is_pad) |-> (last_r && bits_r == '0))
  // a plain byte only emits full symbols
  `ASSERT_CLK(a_plain_full, clk, rst_n, (step && !last_r) |-> bits_r >= SYMBOL_BITS)

endmodule

// File: dv/testbench.sv
// testbench for the base32 stream encoder: directed table, random messages, scoreboard
`timescale 1ns / 100ps

module testbench;
  import b32e_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 160;
  localparam int unsigned QUIET_FROM = 130;
  localparam int unsigned LONG_HOLD_AT = 120;
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [6:0] LETTER_BASE = 7'h41;
  localparam logic [6:0] DIGIT_BASE = 7'h32;
  localparam int unsigned ALPHA_SPAN = 26;
  localparam int unsigned DIRECTED_ROWS = 24;

  typedef struct packed {
    logic [6:0] code;
    logic       pad;
    logic       last;
  } b32_char_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [3:0]  n_typed;
    logic [63:0] txt;
  } dir_row_t;

  // n_typed of zero means the row is checked against the encoder model
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 4'd8, "AA999999"},
    '{8'hFF, 1'b1, 4'd8, "74999999"},
    '{8'h80, 1'b1, 4'd8, "QA999999"},
    '{8'h01, 1'b1, 4'd8, "AE999999"},
    '{8'h00, 1'b0, 4'd0, 64'd0},
    '{8'h00, 1'b0, 4'd0, 64'd0},
    '{8'h00, 1'b0, 4'd0, 64'd0},
    '{8'h00, 1'b0, 4'd0, 64'd0},
    '{8'h00, 1'b1, 4'd0, 64'd0},
    '{8'hFF, 1'b0, 4'd0, 64'd0},
    '{8'hFF, 1'b0, 4'd0, 64'd0},
    '{8'hFF, 1'b0, 4'd0, 64'd0},
    '{8'hFF, 1'b0, 4'd0, 64'd0},
    '{8'hFF, 1'b1, 4'd0, 64'd0},
    '{8'h55, 1'b0, 4'd0, 64'd0},
    '{8'hAA, 1'b1, 4'd0, 64'd0},
    '{8'h12, 1'b0, 4'd0, 64'd0},
    '{8'h34, 1'b0, 4'd0, 64'd0},
    '{8'h56, 1'b1, 4'd0, 64'd0},
    '{8'hDE, 1'b0, 4'd0, 64'd0},
    '{8'hAD, 1'b0, 4'd0, 64'd0},
    '{8'hBE, 1'b0, 4'd0, 64'd0},
    '{8'hEF, 1'b1, 4'd0, 64'd0},
    '{8'h7F, 1'b1, 4'd8, "P4999999"}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char_code;
  logic       out_is_pad;
  logic       out_final_char;

  logic [3:0] carry_bits = 4'd0;
  logic [2:0] carry_cnt = 3'd0;
  logic [2:0] grp_pos = 3'd0;

  b32_char_t   pending_chars[$];
  bit          failed = 1'b0;
  bit          quiet = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned chars_seen = 0;
  int unsigned rx_stall = 0;
  int unsigned cycles = 0;

  base32_stream_encoder_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_is_pad    (out_is_pad),
    .out_final_char(out_final_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [6:0] symbol_of(input logic [4:0] v);
    if (v < 5'(ALPHA_SPAN)) begin
      return LETTER_BASE + 7'(v);
    end
    return DIGIT_BASE + 7'(v) - 7'(ALPHA_SPAN);
  endfunction

  // advances the encoder state by one byte and returns the characters it yields
  function automatic int unsigned encode_byte(input logic [7:0] d, input logic fin,
                                              output b32_char_t res [8]);
    int unsigned acc;
    int unsigned total;
    int unsigned n;
    acc = {20'd0, carry_bits, d};
    total = int'(carry_cnt) + 8;
    n = 0;
    for (int k = 0; k < 8; k++) res[k] = '0;
    while (total >= 5) begin
      total -= 5;
      res[n] = '{symbol_of(5'(acc >> total)), 1'b0, 1'b0};
      n++;
      grp_pos++;
    end
    acc &= (1 << total) - 1;
    if (!fin) begin
      carry_bits = 4'(acc);
      carry_cnt = 3'(total);
      return n;
    end
    if (total > 0) begin
      res[n] = '{symbol_of(5'(acc << (5 - total))), 1'b0, 1'b0};
      n++;
      grp_pos++;
    end
    while (grp_pos != 3'd0 && n < 8) begin
      res[n] = '{PAD_CHAR, 1'b1, 1'b0};
      n++;
      grp_pos++;
    end
    res[n - 1].last = 1'b1;
    carry_bits = 4'd0;
    carry_cnt = 3'd0;
    grp_pos = 3'd0;
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic fin,
                           input logic [3:0] n_typed, input logic [63:0] txt);
    b32_char_t   res [8];
    int unsigned n;
    logic [7:0]  c;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    n = encode_byte(d, fin, res);
    if (n_typed != 4'd0) begin
      for (int i = 0; i < int'(n_typed); i++) begin
        c = txt[8 * (int'(n_typed) - 1 - i) +: 8];
        pending_chars.push_back('{c[6:0], c[6:0] == PAD_CHAR, i == int'(n_typed) - 1});
      end
    end else begin
      for (int i = 0; i < int'(n); i++) pending_chars.push_back(res[i]);
    end
  endtask

  // output side: random stall bursts, one long hold to back up the input
  always @(negedge clk) begin
    logic nxt;
    nxt = 1'b1;
    if (rx_stall > 0) begin
      rx_stall--;
      nxt = 1'b0;
    end else if (!long_hold_done && chars_seen >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      rx_stall = LONG_HOLD_CYCLES - 1;
      nxt = 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rx_stall = $urandom_range(0, 16);
      nxt = 1'b0;
    end
    out_ready <= nxt;
  end

  always @(posedge clk) begin
    b32_char_t want;
    if (rst_n && out_valid && out_ready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $error("unexpected transaction: char_code %h", out_char_code);
        failed = 1'b1;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_code !== want.code) begin
          $error("char_code: expected %h, got %h", want.code, out_char_code);
          failed = 1'b1;
        end
        if (out_is_pad !== want.pad) begin
          $error("is_pad: expected %b, got %b", want.pad, out_is_pad);
          failed = 1'b1;
        end
        if (out_final_char !== want.last) begin
          $error("final_char: expected %b, got %b", want.last, out_final_char);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("base32_stream_encoder_core: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    logic [7:0]  d;
    sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_byte(DIRECTED[r].data, DIRECTED[r].fin, DIRECTED[r].n_typed, DIRECTED[r].txt);
    end

    // sender holds off until the scoreboard is empty
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);

    while (sent < RANDOM_BYTES) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      for (int k = 0; k < int'(len); k++) begin
        if (sent >= QUIET_FROM) quiet = 1'b1;
        case ($urandom_range(0, 7))
          0: d = 8'h00;
          1: d = 8'hFF;
          default: d = 8'($urandom);
        endcase
        send_byte(d, k == int'(len) - 1, 4'd0, 64'd0);
        sent++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("base32_stream_encoder_core: match");
    end else begin
      $display("base32_stream_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/b32e_pkg.sv
design/b32e_char_gen.sv
design/base32_stream_encoder_core.sv
dv/testbench.sv
